// File: hdl/cobp_pkg.sv
`default_nettype none

package cobp_pkg;

    localparam int MAX_OBJECTS_DEF = 8;
    localparam int WORD_W          = 16;
    localparam int OBJ_WORDS       = 5;
    localparam int LANE_W          = 3;
    localparam int ASM_W           = 3;
    localparam int SUM_W           = WORD_W + 3;
    localparam int CFG_W           = 8;
    localparam int CFG_IDX_W       = 1;
    localparam int INDEX_W         = 6;

    localparam logic [WORD_W-1:0] SYNC_WORD   = 16'haa55;
    localparam logic [ASM_W-1:0]  BLOCK_WORDS = 3'd7;

    localparam logic [CFG_W-1:0] IDLE_LIMIT_RST = 8'd16;
    localparam logic [CFG_W-1:0] EMPTY_THR_RST  = 8'd5;

    localparam logic [CFG_IDX_W-1:0] REG_IDLE_LIMIT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_EMPTY_THR  = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_START,
        S_EMIT
    } t_emit_state;

    typedef struct packed {
        logic              en;
        logic [LANE_W-1:0] lane;
        logic [WORD_W-1:0] data;
    } t_blk_wr;

    typedef struct packed {
        logic done;
        logic completed;
        logic empty;
    } t_sess_end;

endpackage

`default_nettype wire

// File: hdl/cobp_session.sv
`default_nettype none

module cobp_session
    import cobp_pkg::*;
#(
    parameter int MAX_OBJECTS = MAX_OBJECTS_DEF,
    parameter int CW          = $clog2(MAX_OBJECTS + 1)
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_acc,
    input  wire logic [WORD_W-1:0] i_word,
    input  wire logic [CFG_W-1:0]  i_idle_limit,
    input  wire logic [CFG_W-1:0]  i_empty_thr,
    output t_blk_wr                o_wr,
    output t_sess_end              o_end,
    output logic [CW-1:0]          o_obj_cnt
);

    logic              r_saving, n_saving;
    logic              r_pending, n_pending;
    logic              r_prev_sync, n_prev_sync;
    logic [CFG_W-1:0]  r_idle, n_idle;
    logic [ASM_W-1:0]  r_asm, n_asm;
    logic [CW-1:0]     r_obj_cnt, n_obj_cnt;
    logic [CFG_W-1:0]  r_esc, n_esc;
    logic [WORD_W-1:0] r_chk, n_chk;
    logic [SUM_W-1:0]  r_sum, n_sum;

    logic              is_sync;
    logic              is_zero;
    logic              keep_ok;
    logic [CFG_W:0]    idle_inc;
    logic              end_sess;
    logic              completed;

    assign is_sync  = (i_word == SYNC_WORD);
    assign is_zero  = (i_word == '0);
    assign keep_ok  = (r_asm == BLOCK_WORDS) && (r_sum == SUM_W'(r_chk))
                   && (r_obj_cnt < CW'(MAX_OBJECTS));
    assign idle_inc = (CFG_W + 1)'(r_idle) + (CFG_W + 1)'(1);

    always_comb begin
        n_saving    = r_saving;
        n_pending   = r_pending;
        n_prev_sync = r_prev_sync;
        n_idle      = r_idle;
        n_asm       = r_asm;
        n_obj_cnt   = r_obj_cnt;
        n_esc       = r_esc;
        n_chk       = r_chk;
        n_sum       = r_sum;
        end_sess    = 1'b0;
        completed   = 1'b0;
        o_wr.en     = 1'b0;
        o_wr.lane   = r_asm - ASM_W'(2);
        o_wr.data   = i_word;

        if (i_acc) begin
            if (!r_saving) begin
                if (is_sync) begin
                    n_obj_cnt   = '0;
                    n_saving    = 1'b1;
                    n_pending   = 1'b1;
                    n_prev_sync = 1'b0;
                    n_asm       = '0;
                    n_idle      = '0;
                end else if (idle_inc >= (CFG_W + 1)'(i_idle_limit)) begin
                    end_sess = 1'b1;
                end else begin
                    n_idle = idle_inc[CFG_W-1:0];
                end
            end else if (is_zero) begin
                if (!r_pending && keep_ok) begin
                    n_obj_cnt = r_obj_cnt + CW'(1);
                end
                end_sess  = 1'b1;
                completed = 1'b1;
            end else if (is_sync) begin
                if (r_prev_sync) begin
                    n_obj_cnt = '0;
                end else if (r_pending) begin
                    n_pending = 1'b0;
                end else if (keep_ok) begin
                    n_obj_cnt = r_obj_cnt + CW'(1);
                end
                n_prev_sync = 1'b1;
                n_asm       = ASM_W'(1);
                n_sum       = '0;
            end else begin
                n_prev_sync = 1'b0;
                if (!r_pending && r_asm != '0 && r_asm < BLOCK_WORDS) begin
                    if (r_asm == ASM_W'(1)) begin
                        n_chk = i_word;
                    end else begin
                        n_sum   = r_sum + SUM_W'(i_word);
                        o_wr.en = (r_obj_cnt < CW'(MAX_OBJECTS));
                    end
                    n_asm = r_asm + ASM_W'(1);
                end
            end
        end

        if (end_sess) begin
            if (completed) begin
                n_esc = '0;
            end else if (r_esc != '1) begin
                n_esc = r_esc + CFG_W'(1);
            end
            n_saving    = 1'b0;
            n_pending   = 1'b0;
            n_prev_sync = 1'b0;
            n_idle      = '0;
            n_asm       = '0;
        end

        o_end.done      = end_sess;
        o_end.completed = completed;
        o_end.empty     = (n_esc >= i_empty_thr);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_saving    <= 1'b0;
            r_pending   <= 1'b0;
            r_prev_sync <= 1'b0;
            r_idle      <= '0;
            r_asm       <= '0;
            r_obj_cnt   <= '0;
            r_esc       <= '0;
        end else begin
            r_saving    <= n_saving;
            r_pending   <= n_pending;
            r_prev_sync <= n_prev_sync;
            r_idle      <= n_idle;
            r_asm       <= n_asm;
            r_obj_cnt   <= n_obj_cnt;
            r_esc       <= n_esc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_chk <= n_chk;
        r_sum <= n_sum;
    end

    assign o_obj_cnt = r_obj_cnt;

endmodule

`default_nettype wire

// File: hdl/camera_object_block_parser_core.sv
// Channel | Direction | Handshake                  | Payload
// in      | input     | i_in_valid / o_in_stall    | i_camera_word
// out     | output    | o_out_valid / i_out_stall  | o_object_valid .. o_last_of_run
// cfg     | input     | i_cfg_we                   | i_cfg_idx, i_cfg_data
//
// A word that does not end a session does not stall the input.
// A session-ending word moves the emitter to its start state; with no stored
// objects it emits one record with o_object_valid low, else it starts the
// object memory read, then emits one object per cycle from the single read port
// of the object memory, fewer when the output side stalls. Input is stalled
// while a run is being emitted. Reset is synchronous and needs no clearing pass.
`default_nettype none

module camera_object_block_parser_core
    import cobp_pkg::*;
#(
    parameter int MAX_OBJECTS = MAX_OBJECTS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic [WORD_W-1:0]    i_camera_word,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic                      o_object_valid,
    output logic [INDEX_W-1:0]        o_object_index,
    output logic [WORD_W-1:0]         o_signature_id,
    output logic [WORD_W-1:0]         o_pos_x,
    output logic [WORD_W-1:0]         o_pos_y,
    output logic [WORD_W-1:0]         o_object_width,
    output logic [WORD_W-1:0]         o_object_height,
    output logic                      o_session_completed,
    output logic                      o_frame_empty,
    output logic                      o_last_of_run,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_data
);

    localparam int CW = $clog2(MAX_OBJECTS + 1);
    localparam int RW = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;

    logic [CFG_W-1:0] r_idle_limit;
    logic [CFG_W-1:0] r_empty_thr;

    t_blk_wr   blk_wr;
    t_sess_end sess_end;
    logic [CW-1:0] obj_cnt;
    logic          in_acc;

    t_emit_state r_state, n_state;
    logic [RW-1:0] r_k, n_k;
    logic          r_completed;
    logic          r_empty;

    logic [OBJ_WORDS-1:0][WORD_W-1:0] r_mem [MAX_OBJECTS];
    logic [OBJ_WORDS-1:0][WORD_W-1:0] r_rd_data;
    logic          rd_en;
    logic [RW-1:0] rd_row;

    logic          out_free;
    logic          load;
    logic          load_obj;
    logic          n_out_valid;
    logic          n_last;
    logic          is_last;

    assign in_acc     = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle_limit <= IDLE_LIMIT_RST;
            r_empty_thr  <= EMPTY_THR_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_IDLE_LIMIT: r_idle_limit <= i_cfg_data;
                REG_EMPTY_THR:  r_empty_thr  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    cobp_session #(
        .MAX_OBJECTS (MAX_OBJECTS),
        .CW          (CW)
    ) u_session (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_acc        (in_acc),
        .i_word       (i_camera_word),
        .i_idle_limit (r_idle_limit),
        .i_empty_thr  (r_empty_thr),
        .o_wr         (blk_wr),
        .o_end        (sess_end),
        .o_obj_cnt    (obj_cnt)
    );

    // object memory: one row per object, one word lane written at a time
    always_ff @(posedge i_clk) begin
        if (blk_wr.en) begin
            r_mem[obj_cnt[RW-1:0]][blk_wr.lane] <= blk_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_mem[rd_row];
        end
    end

    assign out_free = !o_out_valid || !i_out_stall;
    assign is_last  = ((CW + 1)'(r_k) + (CW + 1)'(1)) == (CW + 1)'(obj_cnt);

    always_comb begin
        n_state     = r_state;
        n_k         = r_k;
        rd_en       = 1'b0;
        rd_row      = r_k;
        load        = 1'b0;
        load_obj    = 1'b0;
        n_last      = 1'b0;
        n_out_valid = o_out_valid && i_out_stall;

        case (r_state)
            S_IDLE: begin
                if (sess_end.done) begin
                    n_state = S_START;
                end
            end
            S_START: begin
                if (obj_cnt == '0) begin
                    if (out_free) begin
                        load        = 1'b1;
                        n_last      = 1'b1;
                        n_out_valid = 1'b1;
                        n_state     = S_IDLE;
                    end
                end else begin
                    rd_en   = 1'b1;
                    rd_row  = '0;
                    n_k     = '0;
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    load        = 1'b1;
                    load_obj    = 1'b1;
                    n_last      = is_last;
                    n_out_valid = 1'b1;
                    if (is_last) begin
                        n_state = S_IDLE;
                    end else begin
                        rd_en  = 1'b1;
                        rd_row = r_k + RW'(1);
                        n_k    = r_k + RW'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            o_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            o_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k <= n_k;
        if (sess_end.done) begin
            r_completed <= sess_end.completed;
            r_empty     <= sess_end.empty;
        end
        if (load) begin
            o_object_valid      <= load_obj;
            o_object_index      <= load_obj ? INDEX_W'(r_k) : '0;
            o_signature_id      <= load_obj ? r_rd_data[0] : '0;
            o_pos_x             <= load_obj ? r_rd_data[1] : '0;
            o_pos_y             <= load_obj ? r_rd_data[2] : '0;
            o_object_width      <= load_obj ? r_rd_data[3] : '0;
            o_object_height     <= load_obj ? r_rd_data[4] : '0;
            o_session_completed <= r_completed;
            o_frame_empty       <= r_empty;
            o_last_of_run       <= n_last;
        end
    end

endmodule

`default_nettype wire
